// ----- rtl/core/tws_pkg.sv -----
// ----------------------------------------------------------------------------
// tws_pkg: shared types and helpers for the three-way parity stripe codec
// Holds the item and result structs, device routing and rotation helpers.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam logic [1:0] PP_RESET   = 2'd2;
  localparam logic       MODE_SPLIT = 1'b0;
  localparam logic       MODE_MERGE = 1'b1;
  localparam logic [7:0] BYTE_ALL   = 8'hFF;

  typedef struct packed {
    logic [7:0] data_0;
    logic [7:0] data_1;
    logic [7:0] data_2;
    logic       short_item;
  } tws_in_t;

  typedef struct packed {
    logic [7:0] out_0;
    logic [7:0] out_1;
    logic [7:0] out_2;
    logic [2:0] valid_mask;
    logic       parity_error;
  } tws_out_t;

  // Device indices for parity, first data byte and second data byte
  typedef struct packed {
    logic [1:0] pp;
    logic [1:0] ia;
    logic [1:0] ib;
  } tws_route_t;

  function automatic tws_route_t route_of(input logic [1:0] pp);
    tws_route_t r;
    case (pp)
      2'd0: begin
        r = '{pp: 2'd0, ia: 2'd1, ib: 2'd2};
      end
      2'd1: begin
        r = '{pp: 2'd1, ia: 2'd2, ib: 2'd0};
      end
      2'd2: begin
        r = '{pp: 2'd2, ia: 2'd0, ib: 2'd1};
      end
      default: begin
        // out-of-range position wraps to device 0
        r = '{pp: 2'd0, ia: 2'd1, ib: 2'd2};
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] next_pp(input logic [1:0] pp);
    logic [1:0] n;
    case (pp)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      2'd2:    n = 2'd0;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/core/tws_split.sv -----
// ----------------------------------------------------------------------------
// tws_split: split datapath
// De-interleave a byte pair, form parity and route bytes to devices.
// ----------------------------------------------------------------------------
module tws_split (
  input  tws_pkg::tws_in_t    item_i,
  input  tws_pkg::tws_route_t route_i,
  output tws_pkg::tws_out_t   res_o
);
  import tws_pkg::*;

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] dev [3];
  logic [2:0] mask;

  // odd-position bits of the pair form a, even-position bits form b
  assign a = {item_i.data_0[7], item_i.data_0[5], item_i.data_0[3], item_i.data_0[1],
              item_i.data_1[7], item_i.data_1[5], item_i.data_1[3], item_i.data_1[1]};
  assign b = {item_i.data_0[6], item_i.data_0[4], item_i.data_0[2], item_i.data_0[0],
              item_i.data_1[6], item_i.data_1[4], item_i.data_1[2], item_i.data_1[0]};

  always_comb begin
    dev[0] = '0;
    dev[1] = '0;
    dev[2] = '0;
    mask   = '0;
    if (!item_i.short_item) begin
      dev[route_i.ia] = a;
      dev[route_i.ib] = b;
      dev[route_i.pp] = a ^ b;
      mask            = 3'b111;
    end else begin
      // tail: lone byte plus its inverse as parity
      dev[route_i.ia]  = item_i.data_0;
      dev[route_i.pp]  = ~item_i.data_0;
      mask[route_i.ia] = 1'b1;
      mask[route_i.pp] = 1'b1;
    end
    res_o.out_0        = dev[0];
    res_o.out_1        = dev[1];
    res_o.out_2        = dev[2];
    res_o.valid_mask   = mask;
    res_o.parity_error = 1'b0;
  end

endmodule

// ----- rtl/core/tws_merge.sv -----
// ----------------------------------------------------------------------------
// tws_merge: merge datapath
// Pick device bytes, re-interleave them and check parity.
// ----------------------------------------------------------------------------
module tws_merge (
  input  tws_pkg::tws_in_t    item_i,
  input  tws_pkg::tws_route_t route_i,
  output tws_pkg::tws_out_t   res_o
);
  import tws_pkg::*;

  logic [7:0] dev [3];
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] p;

  assign dev[0] = item_i.data_0;
  assign dev[1] = item_i.data_1;
  assign dev[2] = item_i.data_2;
  assign a      = dev[route_i.ia];
  assign b      = dev[route_i.ib];
  assign p      = dev[route_i.pp];

  always_comb begin
    res_o.out_2 = '0;
    if (!item_i.short_item) begin
      res_o.out_0        = {a[7], b[7], a[6], b[6], a[5], b[5], a[4], b[4]};
      res_o.out_1        = {a[3], b[3], a[2], b[2], a[1], b[1], a[0], b[0]};
      res_o.valid_mask   = 3'b011;
      res_o.parity_error = ((a ^ b) != p);
    end else begin
      // tail: parity holds the inverse of the lone byte
      res_o.out_0        = a;
      res_o.out_1        = '0;
      res_o.valid_mask   = 3'b001;
      res_o.parity_error = ((a ^ p) != BYTE_ALL);
    end
  end

endmodule

// ----- rtl/core/three_way_parity_stripe_codec_core.sv -----
// ----------------------------------------------------------------------------
// three_way_parity_stripe_codec_core: three-device striping codec top level
// Split byte pairs into rotating data/parity device bytes, or merge them back.
// ----------------------------------------------------------------------------
// Result path: an accepted transaction goes into the input register, then the
//   result register, which drives the output; a stall can hold either stage.
// Throughput: one transaction per cycle while the receiver takes results; both
//   register stages advance when the next stage is free or being drained.
// Reset: asynchronous, active low; clears both stages, mode to split and the
//   parity position to device 2. A mode write also returns the position to 2.
module three_way_parity_stripe_codec_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tws_pkg::tws_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tws_pkg::tws_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);
  import tws_pkg::*;

  // configuration and rotation state
  logic       mode_q, mode_d;
  logic [1:0] pp_q, pp_d;

  // input stage
  logic       s1_valid_q, s1_valid_d;
  tws_in_t    s1_item_q;
  logic [1:0] s1_pp_q;
  logic       s1_mode_q;

  // result stage
  logic       s2_valid_q, s2_valid_d;
  tws_out_t   s2_res_q;

  logic       in_fire;
  logic       s2_free;
  tws_route_t route;
  tws_out_t   split_res;
  tws_out_t   merge_res;
  tws_out_t   res;

  // result stage takes a new value when empty or being drained
  assign s2_free    = !s2_valid_q || out_ready_i;
  // input stage takes a transaction when empty or moving into the result stage
  assign in_ready_o = !s1_valid_q || s2_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // mode write restarts rotation; otherwise advance once per transaction
  always_comb begin
    mode_d = mode_q;
    pp_d   = pp_q;
    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      pp_d   = PP_RESET;
    end else if (in_fire) begin
      pp_d = next_pp(pp_q);
    end
  end

  always_comb begin
    s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;
    s2_valid_d = s2_free ? s1_valid_q : s2_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_SPLIT;
      pp_q       <= PP_RESET;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      pp_q       <= pp_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // payload registers: capture the item with the parity position and mode
  // that were in force when it was accepted
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
      s1_pp_q   <= pp_q;
      s1_mode_q <= mode_q;
    end
    if (s2_free && s1_valid_q) begin
      s2_res_q <= res;
    end
  end

  assign route = route_of(s1_pp_q);

  tws_split u_split (
    .item_i  (s1_item_q),
    .route_i (route),
    .res_o   (split_res)
  );

  tws_merge u_merge (
    .item_i  (s1_item_q),
    .route_i (route),
    .res_o   (merge_res)
  );

  assign res = (s1_mode_q == MODE_MERGE) ? merge_res : split_res;

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_res_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a mode write always returns the parity position to device 2
  a_cfg_restarts_rotation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (pp_q == PP_RESET))
    else $error("parity position not restarted by mode write");

  // each transaction advances the rotation by exactly one device
  a_rotation_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i) |=> (pp_q == next_pp($past(pp_q))))
    else $error("parity position did not advance by one");

  // bytes without a valid bit are zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.valid_mask[0] || out_data_o.out_0 == 8'h00) &&
                     (out_data_o.valid_mask[1] || out_data_o.out_1 == 8'h00) &&
                     (out_data_o.valid_mask[2] || out_data_o.out_2 == 8'h00)))
    else $error("unused result byte is not zero");

  // a parity error only comes from merge, which never drives device 2
  a_error_only_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.parity_error) |-> !out_data_o.valid_mask[2])
    else $error("parity error flagged on a split result");

endmodule

// ----- verif/three_way_parity_stripe_codec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_way_parity_stripe_codec_checker: result checker for the stripe codec
// Watches the mode port and both channels. Predicts the striped or merged
// bytes of each input transaction and compares every result against them.
// ----------------------------------------------------------------------------
module three_way_parity_stripe_codec_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  tws_pkg::tws_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tws_pkg::tws_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  output int                mismatch_count_o,
  output int                outstanding_o
);
  import tws_pkg::*;

  logic       cur_mode;
  logic [1:0] rot_dev;
  tws_out_t   expected_stripes [$];
  tws_out_t   want;
  int         result_idx;
  int         mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Expected result for one item, given the mode and the parity device
  function automatic tws_out_t predict_stripe(input tws_in_t item, input logic m,
                                              input logic [1:0] pos);
    logic [7:0]  dev [3];
    logic [15:0] pair;
    logic [7:0]  a, b, p;
    int          ip, ia, ib;
    tws_out_t    res;
    ip = pos;
    ia = (ip + 1) % 3;
    ib = (ip + 2) % 3;
    res = '0;
    if (m == MODE_SPLIT) begin
      dev[0] = 8'h00;
      dev[1] = 8'h00;
      dev[2] = 8'h00;
      if (item.short_item) begin
        dev[ia] = item.data_0;
        dev[ip] = ~item.data_0;
        res.valid_mask[ia] = 1'b1;
        res.valid_mask[ip] = 1'b1;
      end else begin
        pair = {item.data_0, item.data_1};
        for (int i = 0; i < 8; i++) begin
          a[7 - i] = pair[15 - 2 * i];
          b[7 - i] = pair[14 - 2 * i];
        end
        dev[ia] = a;
        dev[ib] = b;
        dev[ip] = a ^ b;
        res.valid_mask = 3'b111;
      end
      res.out_0 = dev[0];
      res.out_1 = dev[1];
      res.out_2 = dev[2];
    end else begin
      dev[0] = item.data_0;
      dev[1] = item.data_1;
      dev[2] = item.data_2;
      a = dev[ia];
      b = dev[ib];
      p = dev[ip];
      if (item.short_item) begin
        res.out_0 = a;
        res.valid_mask = 3'b001;
        res.parity_error = ((a ^ p) != BYTE_ALL);
      end else begin
        res.out_0 = {a[7], b[7], a[6], b[6], a[5], b[5], a[4], b[4]};
        res.out_1 = {a[3], b[3], a[2], b[2], a[1], b[1], a[0], b[0]};
        res.valid_mask = 3'b011;
        res.parity_error = ((a ^ b) != p);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [27:0] got,
                                 input logic [27:0] exp_val);
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $time, result_idx, field, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode = MODE_SPLIT;
      rot_dev = PP_RESET;
      expected_stripes.delete();
      result_idx = 0;
      outstanding_o <= 0;
    end else begin
      // a mode write also restarts the parity rotation
      if (cfg_we_i) begin
        cur_mode = cfg_wdata_i;
        rot_dev = PP_RESET;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_stripes.size() == 0) begin
          report_mismatch("unexpected result", out_data_i, '0);
        end else begin
          want = expected_stripes.pop_front();
          if (out_data_i.out_0 !== want.out_0)
            report_mismatch("out_0", 28'(out_data_i.out_0), 28'(want.out_0));
          if (out_data_i.out_1 !== want.out_1)
            report_mismatch("out_1", 28'(out_data_i.out_1), 28'(want.out_1));
          if (out_data_i.out_2 !== want.out_2)
            report_mismatch("out_2", 28'(out_data_i.out_2), 28'(want.out_2));
          if (out_data_i.valid_mask !== want.valid_mask)
            report_mismatch("valid_mask", 28'(out_data_i.valid_mask),
                            28'(want.valid_mask));
          if (out_data_i.parity_error !== want.parity_error)
            report_mismatch("parity_error", 28'(out_data_i.parity_error),
                            28'(want.parity_error));
        end
        result_idx++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_stripes.push_back(predict_stripe(in_data_i, cur_mode, rot_dev));
        rot_dev = (rot_dev == 2'd2) ? 2'd0 : rot_dev + 2'd1;
      end
      outstanding_o <= expected_stripes.size();
    end
  end

endmodule

// ----- verif/three_way_parity_stripe_codec_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_way_parity_stripe_codec_core_tb: testbench top for the stripe codec
// Runs directed and random split and merge transactions through a series of
// mode settings, with bursty input and a stalling receiver; the checker beside
// the block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module three_way_parity_stripe_codec_core_tb;
  import tws_pkg::*;

  localparam int CLK_HALF_NS     = 5;
  localparam int RESET_CYCLES    = 10;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int PRESSURE_ITEMS  = 24;
  localparam int PHASES          = 6;
  // two register stages, plus margin
  localparam int SETTLE_CYCLES   = 4;
  localparam int STALL_LIMIT     = 2000;

  // Receiver behavior over one stretch of cycles
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_style_e;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  tws_in_t    in_data      = '0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  tws_out_t   out_data;
  logic       cfg_we       = 1'b0;
  logic       cfg_wdata    = MODE_SPLIT;
  int         mismatch_count;
  int         outstanding;
  // parity device the next item will meet, tracked on the stimulus side
  logic [1:0] stripe_pos   = PP_RESET;
  logic       hold_off_req = 1'b0;
  logic       drain        = 1'b0;
  logic       phase_mode [PHASES] = '{MODE_SPLIT, MODE_MERGE, MODE_MERGE,
                                      MODE_SPLIT, MODE_SPLIT, MODE_MERGE};

  three_way_parity_stripe_codec_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  three_way_parity_stripe_codec_checker stripe_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin : clock_gen
    forever begin
      #CLK_HALF_NS clk = ~clk;
    end
  end

  // Split item: the pair goes to data_0:data_1, data_2 carries junk that
  // the block must ignore
  function automatic tws_in_t split_item(input logic [15:0] pair, input logic tail);
    tws_in_t item;
    item.data_0     = pair[15:8];
    item.data_1     = pair[7:0];
    item.data_2     = 8'($urandom);
    item.short_item = tail;
    return item;
  endfunction

  // Merge item: place a, b and parity on the devices the current rotation
  // assigns them to
  function automatic tws_in_t place_stripe(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] p, input logic tail);
    logic [7:0] dev [3];
    int         pp;
    pp = stripe_pos;
    dev[(pp + 1) % 3] = a;
    dev[(pp + 2) % 3] = b;
    dev[pp]           = p;
    return tws_in_t'({dev[0], dev[1], dev[2], tail});
  endfunction

  // Random item. In merge mode most stripes are consistent, some carry a
  // flipped parity bit, and a few are plain noise.
  function automatic tws_in_t random_item(input logic m);
    logic [7:0] a, b, p;
    logic       tail;
    int         kind;
    a    = 8'($urandom);
    b    = 8'($urandom);
    tail = ($urandom_range(0, 4) == 0);
    kind = $urandom_range(0, 19);
    if (m == MODE_SPLIT) begin
      return split_item(16'($urandom), tail);
    end
    if (kind < 3) begin
      return tws_in_t'({8'($urandom), 8'($urandom), 8'($urandom), tail});
    end
    p = tail ? ~a : a ^ b;
    if (kind < 6) begin
      p = p ^ (8'h01 << $urandom_range(0, 7));
    end
    return place_stripe(a, b, p, tail);
  endfunction

  // Offer one transaction and hold it until accepted. Valid stays high on
  // return so back-to-back items need no extra cycle.
  task automatic send_item(input tws_in_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    stripe_pos = (stripe_pos == 2'd2) ? 2'd0 : stripe_pos + 2'd1;
  endtask

  // Drop valid and wait until every expected result has been taken. The
  // first edge lets the checker count an item accepted on the calling edge.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the mode only while idle; any write restarts the rotation at 2
  task automatic write_mode(input logic m);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    stripe_pos = PP_RESET;
  endtask

  initial begin : stimulus
    int burst;
    int gap;
    int count;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Split: all-zero and all-one pairs, alternating bits that land wholly in
    // a or in b, the corner bits, and tails of every shape
    write_mode(MODE_SPLIT);
    send_item(split_item(16'h0000, 1'b0));
    send_item(split_item(16'hFFFF, 1'b0));
    send_item(split_item(16'hAAAA, 1'b0));
    send_item(split_item(16'h5555, 1'b0));
    send_item(split_item(16'h8001, 1'b0));
    send_item(split_item(16'h00FF, 1'b1));
    send_item(split_item(16'hFF00, 1'b1));
    send_item(split_item(16'h8000, 1'b1));
    send_item(split_item(16'h1234, 1'b0));

    // Merge: clean stripes, bad parity, clean tails and tails whose parity
    // is not the inverse of a
    write_mode(MODE_MERGE);
    send_item(place_stripe(8'hFF, 8'h00, 8'hFF, 1'b0));
    send_item(place_stripe(8'h00, 8'hFF, 8'hFF, 1'b0));
    send_item(place_stripe(8'h5A, 8'hC3, 8'h99, 1'b0));
    send_item(place_stripe(8'h5A, 8'hC3, 8'h98, 1'b0));
    send_item(place_stripe(8'h00, 8'h00, 8'h00, 1'b0));
    send_item(place_stripe(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_item(place_stripe(8'h80, 8'h3C, 8'h7F, 1'b1));
    send_item(place_stripe(8'h80, 8'h3C, 8'h80, 1'b1));
    send_item(place_stripe(8'h00, 8'hFF, 8'hFF, 1'b1));
    send_item(place_stripe(8'hFF, 8'h00, 8'h00, 1'b1));

    // Random phases, each opened by a mode write (repeated values included)
    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(phase_mode[ph]);
      count = $urandom_range(90, 110);
      if (ph == 1) begin
        // Hold the receiver off and keep offering back to back so both
        // stages fill and in_ready drops
        hold_off_req = 1'b1;
        repeat (PRESSURE_ITEMS) send_item(random_item(phase_mode[ph]));
      end
      while (count > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > count) begin
          burst = count;
        end
        repeat (burst) send_item(random_item(phase_mode[ph]));
        count -= burst;
        // mostly short gaps or none, now and then a longer one
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // Open the receiver and wait out the last results
    drain = 1'b1;
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: stretches of random length, each with its own stall style,
  // plus the one long hold-off the stimulus asks for
  initial begin : rx_pattern
    rx_style_e style;
    int        span;
    logic      take;
    logic      held;
    style = RX_OPEN;
    span  = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        held = 1'b1;
      end else begin
        if (span == 0) begin
          span  = $urandom_range(1, 40);
          style = rx_style_e'($urandom_range(0, 3));
        end
        span--;
        case (style)
          RX_OPEN:  take = 1'b1;
          RX_LIGHT: take = ($urandom_range(0, 3) != 0);
          RX_HEAVY: take = ($urandom_range(0, 3) == 0);
          default:  take = ~out_ready;
        endcase
        out_ready <= take | drain;
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either channel for
  // too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
